// ===== hdl/dbb_pkg.sv =====
// dbb_pkg: types, codes and reset values shared by the dash button/buzzer controller
// no dependencies; compiled first

package dbb_pkg;

	// action codes
	localparam logic [1:0] ACT_POLL      = 2'd0;
	localparam logic [1:0] ACT_READY_OFF = 2'd1;
	localparam logic [1:0] ACT_READY_ON  = 2'd2;

	// pack state classes
	localparam logic [1:0] PACK_OTHER     = 2'd0;
	localparam logic [1:0] PACK_ENERGIZED = 2'd1;
	localparam logic [1:0] PACK_DRIVE     = 2'd2;
	localparam logic [1:0] PACK_UNUSED    = 2'd3;

	// indicator colours
	localparam logic [1:0] COLOUR_RED    = 2'd0;
	localparam logic [1:0] COLOUR_YELLOW = 2'd1;
	localparam logic [1:0] COLOUR_GREEN  = 2'd2;

	// button byte bit positions
	localparam int unsigned BTN_READY = 1;
	localparam int unsigned BTN_AUTO  = 2;
	localparam logic [7:0] SWITCH_MASK = 8'hE0;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_BRAKE_MIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTER_BUZZ_MS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_BUZZ_MS  = 2'd3;

	// register reset values
	localparam logic [7:0]  BRAKE_MIN_RST     = 8'd20;
	localparam logic [15:0] HOLD_MS_RST       = 16'd2000;
	localparam logic [15:0] ENTER_BUZZ_MS_RST = 16'd2000;
	localparam logic [15:0] EXIT_BUZZ_MS_RST  = 16'd500;

	typedef struct packed {
		logic [7:0]  brake_min;
		logic [15:0] hold_ms;
		logic [15:0] enter_buzz_ms;
		logic [15:0] exit_buzz_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now_ms;
		logic [7:0]  buttons;
		logic [7:0]  brake_pos;
		logic        inverter_on;
		logic [1:0]  pack_class;
		logic        pack_fault;
	} poll_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic       ready_frame_sent;
		logic       buzzer_n;
		logic       fault_lamp;
		logic [1:0] ready_colour;
		logic       ready_flag;
	} result_t;

endpackage

// ===== hdl/dbb_if.sv =====
// dbb_poll_if / dbb_result_if: valid/ready channels for poll and result beats
// depends on dbb_pkg

interface dbb_poll_if;
	import dbb_pkg::*;

	logic  valid;
	logic  ready;
	poll_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

interface dbb_result_if;
	import dbb_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

// ===== hdl/dash_button_buzzer_controller_top.sv =====
// dash_button_buzzer_controller_top: input register, controller core, result register
// depends on dbb_pkg, dbb_if, dbb_cfg_regs, dbb_core
// path: a poll beat waits in the input register, its result beat in the result register
// throughput: one beat per cycle unless stalled; input register fills while result waits
// reset: arst_n clears registers to their reset values, state to zero, no beats in flight

module dash_button_buzzer_controller_top (
	input  logic                           clk,
	input  logic                           arst_n,
	dbb_poll_if.sink                       poll,
	dbb_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [dbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dbb_pkg::*;

	cfg_t    cfg;
	poll_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign poll.ready = !valid_s1 || adv;

	dbb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dbb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (poll.ready) begin
				valid_s1 <= poll.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			item_s1 <= poll.data;
		end
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

endmodule

// ===== hdl/dbb_cfg_regs.sv =====
// dbb_cfg_regs: configuration register file with write port
// depends on dbb_pkg

module dbb_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbb_pkg::CFG_DATA_W-1:0] cfg_data,
	output dbb_pkg::cfg_t                  cfg
);
	import dbb_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brake_min     <= BRAKE_MIN_RST;
			cfg_q.hold_ms       <= HOLD_MS_RST;
			cfg_q.enter_buzz_ms <= ENTER_BUZZ_MS_RST;
			cfg_q.exit_buzz_ms  <= EXIT_BUZZ_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BRAKE_MIN:     cfg_q.brake_min     <= cfg_data[7:0];
				REG_HOLD_MS:       cfg_q.hold_ms       <= cfg_data;
				REG_ENTER_BUZZ_MS: cfg_q.enter_buzz_ms <= cfg_data;
				REG_EXIT_BUZZ_MS:  cfg_q.exit_buzz_ms  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/dbb_core.sv =====
// dbb_core: controller state and the single-pass next-state and result logic
// depends on dbb_pkg

module dbb_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  dbb_pkg::poll_t  item,
	input  dbb_pkg::cfg_t   cfg,
	output dbb_pkg::result_t res
);
	import dbb_pkg::*;

	logic [1:0]  last_pack_q, last_pack_d;
	logic [31:0] ready_start_q, ready_start_d;
	logic [31:0] auto_start_q, auto_start_d;
	logic        ready_req_q, ready_req_d;
	logic        auto_on_q, auto_on_d;
	logic        entered_q, entered_d;
	logic        exited_q, exited_d;
	logic [31:0] enter_start_q, enter_start_d;
	logic [31:0] exit_start_q, exit_start_d;

	logic [1:0]  cur;
	logic [1:0]  colour;
	logic [31:0] ready_age, auto_age, enter_age, exit_age;
	logic        frame, buz, end_enter, end_exit;

	always_comb begin
		last_pack_d   = last_pack_q;
		ready_start_d = ready_start_q;
		auto_start_d  = auto_start_q;
		ready_req_d   = ready_req_q;
		auto_on_d     = auto_on_q;
		entered_d     = entered_q;
		exited_d      = exited_q;
		enter_start_d = enter_start_q;
		exit_start_d  = exit_start_q;
		frame         = 1'b0;
		buz           = 1'b1;
		colour        = COLOUR_RED;
		end_enter     = 1'b0;
		end_exit      = 1'b0;
		cur           = (item.pack_class == PACK_UNUSED) ? PACK_OTHER : item.pack_class;
		ready_age     = item.now_ms - ready_start_q;
		auto_age      = item.now_ms - auto_start_q;
		enter_age     = 32'd0;
		exit_age      = 32'd0;
		res           = '0;

		if (item.action != ACT_POLL) begin
			if (item.action == ACT_READY_OFF) begin
				ready_req_d = 1'b0;
			end else if (item.action == ACT_READY_ON) begin
				ready_req_d = 1'b1;
			end
			res.buzzer_n   = 1'b1;
			res.ready_flag = ready_req_d;
		end else begin
			last_pack_d = cur;
			if (last_pack_q == PACK_ENERGIZED && cur == PACK_DRIVE) begin
				entered_d = 1'b1;
			end else if (last_pack_q == PACK_DRIVE && cur == PACK_ENERGIZED) begin
				exited_d = 1'b1;
			end

			if (cur == PACK_DRIVE) begin
				colour = item.inverter_on ? COLOUR_GREEN : COLOUR_YELLOW;
			end else if (cur == PACK_ENERGIZED) begin
				colour = COLOUR_YELLOW;
			end

			// ready button hold
			if (item.buttons[BTN_READY]) begin
				if (ready_age >= {16'd0, cfg.hold_ms} && item.brake_pos >= cfg.brake_min &&
				    (cur == PACK_ENERGIZED || cur == PACK_DRIVE)) begin
					ready_req_d   = (cur == PACK_ENERGIZED);
					frame         = 1'b1;
					ready_start_d = item.now_ms;
				end
			end else begin
				ready_start_d = item.now_ms;
			end

			// auto button hold
			if (item.buttons[BTN_AUTO]) begin
				if (auto_age >= {16'd0, cfg.hold_ms}) begin
					auto_on_d    = !auto_on_q;
					auto_start_d = item.now_ms;
				end
			end else begin
				auto_start_d = item.now_ms;
			end

			// buzzer timing, zero start means idle
			if (entered_d && cur == PACK_DRIVE && item.inverter_on) begin
				if (enter_start_q == 32'd0) begin
					enter_start_d = item.now_ms;
				end
				buz = 1'b0;
			end else if (exited_d && cur == PACK_ENERGIZED && !item.inverter_on) begin
				if (exit_start_q == 32'd0) begin
					exit_start_d = item.now_ms;
				end
				buz = 1'b0;
			end
			enter_age = item.now_ms - enter_start_d;
			exit_age  = item.now_ms - exit_start_d;
			end_enter = (enter_start_d != 32'd0) && (enter_age >= {16'd0, cfg.enter_buzz_ms});
			end_exit  = (exit_start_d != 32'd0) && (exit_age >= {16'd0, cfg.exit_buzz_ms});
			if (end_enter || end_exit) begin
				enter_start_d = 32'd0;
				exit_start_d  = 32'd0;
				entered_d     = 1'b0;
				exited_d      = 1'b0;
				buz           = 1'b1;
			end

			res.status_byte      = (item.buttons & SWITCH_MASK) |
			                       {5'd0, auto_on_d, ready_req_d, buz};
			res.ready_frame_sent = frame;
			res.buzzer_n         = buz;
			res.fault_lamp       = !item.pack_fault;
			res.ready_colour     = colour;
			res.ready_flag       = ready_req_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pack_q   <= PACK_OTHER;
			ready_start_q <= 32'd0;
			auto_start_q  <= 32'd0;
			ready_req_q   <= 1'b0;
			auto_on_q     <= 1'b0;
			entered_q     <= 1'b0;
			exited_q      <= 1'b0;
			enter_start_q <= 32'd0;
			exit_start_q  <= 32'd0;
		end else if (adv) begin
			last_pack_q   <= last_pack_d;
			ready_start_q <= ready_start_d;
			auto_start_q  <= auto_start_d;
			ready_req_q   <= ready_req_d;
			auto_on_q     <= auto_on_d;
			entered_q     <= entered_d;
			exited_q      <= exited_d;
			enter_start_q <= enter_start_d;
			exit_start_q  <= exit_start_d;
		end
	end

endmodule

// ===== hdl/dbb_checker.sv =====
// dbb_checker: port-level assertions for the controller, bound to the top level
// depends on dbb_pkg and dbb_if

module dbb_checker (
	input logic          clk,
	input logic          arst_n,
	dbb_poll_if.sink     poll,
	dbb_result_if.source result
);
	import dbb_pkg::*;

	// result beat holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.data))
		else $error("result beat dropped or changed while stalled");

	// nothing comes out in the first cycle after reset
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !result.valid)
		else $error("result beat right after reset");

	// a sounding buzzer only comes from a poll, whose status mirrors the flags
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.data.buzzer_n |->
			!result.data.status_byte[0] &&
			result.data.status_byte[1] == result.data.ready_flag &&
			result.data.ready_colour != COLOUR_RED)
		else $error("buzzer beat inconsistent with status");

	// a ready hold fires only in an energized or drive state
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.ready_frame_sent |->
			result.data.ready_colour != COLOUR_RED &&
			result.data.status_byte[1] == result.data.ready_flag)
		else $error("ready frame outside energized or drive");

endmodule

bind dash_button_buzzer_controller_top dbb_checker u_dbb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.poll   (poll),
	.result (result)
);

// ===== sim/dbb_status_checker.sv =====
// dbb_status_checker: watches the poll, result and register write ports of the dash controller,
// predicts each result beat and compares it field by field with what the block returns
// depends on dbb_pkg and dbb_if

module dbb_status_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	dbb_poll_if.monitor                    poll,
	dbb_result_if.monitor                  result,
	input  logic                           cfg_we,
	input  logic [dbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbb_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding
);
	import dbb_pkg::*;

	cfg_t        settings;
	logic [1:0]  last_class;
	logic [31:0] ready_since;
	logic [31:0] auto_since;
	logic [31:0] enter_buzz_t0;
	logic [31:0] exit_buzz_t0;
	logic        ready_req;
	logic        auto_on;
	logic        drive_entered;
	logic        drive_left;
	result_t     expected_status[$];

	function automatic result_t predict_status(input poll_t p);
		result_t    r;
		logic [1:0] cls;
		logic [1:0] prev;
		logic       buz;
		logic       end_enter;
		logic       end_exit;
		r = '0;
		r.buzzer_n = 1'b1;
		if (p.action != ACT_POLL) begin
			if (p.action == ACT_READY_OFF)
				ready_req = 1'b0;
			else if (p.action == ACT_READY_ON)
				ready_req = 1'b1;
			r.ready_flag = ready_req;
			return r;
		end
		cls = (p.pack_class == PACK_UNUSED) ? PACK_OTHER : p.pack_class;
		prev = last_class;
		last_class = cls;
		if (prev == PACK_ENERGIZED && cls == PACK_DRIVE)
			drive_entered = 1'b1;
		else if (prev == PACK_DRIVE && cls == PACK_ENERGIZED)
			drive_left = 1'b1;
		case (cls)
			PACK_DRIVE: r.ready_colour = p.inverter_on ? COLOUR_GREEN : COLOUR_YELLOW;
			PACK_ENERGIZED: r.ready_colour = COLOUR_YELLOW;
			default: r.ready_colour = COLOUR_RED;
		endcase
		if (p.buttons[BTN_READY]) begin
			if (32'(p.now_ms - ready_since) >= 32'(settings.hold_ms) &&
			    p.brake_pos >= settings.brake_min && cls != PACK_OTHER) begin
				ready_req = (cls == PACK_ENERGIZED);
				r.ready_frame_sent = 1'b1;
				ready_since = p.now_ms;
			end
		end else begin
			ready_since = p.now_ms;
		end
		if (p.buttons[BTN_AUTO]) begin
			if (32'(p.now_ms - auto_since) >= 32'(settings.hold_ms)) begin
				auto_on = !auto_on;
				auto_since = p.now_ms;
			end
		end else begin
			auto_since = p.now_ms;
		end
		// a start time of zero means the buzzer timer is idle
		if (drive_entered && cls == PACK_DRIVE && p.inverter_on) begin
			if (enter_buzz_t0 == 32'd0)
				enter_buzz_t0 = p.now_ms;
			buz = 1'b0;
		end else if (drive_left && cls == PACK_ENERGIZED && !p.inverter_on) begin
			if (exit_buzz_t0 == 32'd0)
				exit_buzz_t0 = p.now_ms;
			buz = 1'b0;
		end else begin
			buz = 1'b1;
		end
		end_enter = enter_buzz_t0 != 32'd0 &&
		            32'(p.now_ms - enter_buzz_t0) >= 32'(settings.enter_buzz_ms);
		end_exit = exit_buzz_t0 != 32'd0 &&
		           32'(p.now_ms - exit_buzz_t0) >= 32'(settings.exit_buzz_ms);
		if (end_enter || end_exit) begin
			enter_buzz_t0 = 32'd0;
			exit_buzz_t0 = 32'd0;
			drive_entered = 1'b0;
			drive_left = 1'b0;
			buz = 1'b1;
		end
		r.status_byte = (p.buttons & SWITCH_MASK) | {5'b00000, auto_on, ready_req, buz};
		r.buzzer_n = buz;
		r.fault_lamp = !p.pack_fault;
		r.ready_flag = ready_req;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%s mismatch: expected %0h, got %0h", field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			settings.brake_min = BRAKE_MIN_RST;
			settings.hold_ms = HOLD_MS_RST;
			settings.enter_buzz_ms = ENTER_BUZZ_MS_RST;
			settings.exit_buzz_ms = EXIT_BUZZ_MS_RST;
			last_class = PACK_OTHER;
			ready_since = '0;
			auto_since = '0;
			enter_buzz_t0 = '0;
			exit_buzz_t0 = '0;
			ready_req = 1'b0;
			auto_on = 1'b0;
			drive_entered = 1'b0;
			drive_left = 1'b0;
			expected_status.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BRAKE_MIN: settings.brake_min = cfg_data[7:0];
					REG_HOLD_MS: settings.hold_ms = cfg_data;
					REG_ENTER_BUZZ_MS: settings.enter_buzz_ms = cfg_data;
					REG_EXIT_BUZZ_MS: settings.exit_buzz_ms = cfg_data;
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				got = result.data;
				if (expected_status.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result beat %0h with no poll waiting", got);
				end else begin
					want = expected_status.pop_front();
					check_field("status_byte", want.status_byte, got.status_byte);
					check_field("ready_frame_sent", 8'(want.ready_frame_sent),
					            8'(got.ready_frame_sent));
					check_field("buzzer_n", 8'(want.buzzer_n), 8'(got.buzzer_n));
					check_field("fault_lamp", 8'(want.fault_lamp), 8'(got.fault_lamp));
					check_field("ready_colour", 8'(want.ready_colour), 8'(got.ready_colour));
					check_field("ready_flag", 8'(want.ready_flag), 8'(got.ready_flag));
				end
			end
			if (poll.valid && poll.ready)
				expected_status.push_back(predict_status(poll.data));
			outstanding <= expected_status.size();
		end
	end

endmodule

// ===== sim/dash_button_buzzer_controller_top_test.sv =====
// dash_button_buzzer_controller_top_test: drives polls and register writes into the controller,
// stalls the result side at random and gives the verdict from the status checker
// depends on dbb_pkg, dbb_if, dash_button_buzzer_controller_top and dbb_status_checker

module dash_button_buzzer_controller_top_test;
	import dbb_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;

	int unsigned step_max = 402;
	logic [7:0]  brake_floor = BRAKE_MIN_RST;
	logic [31:0] tick = '0;
	logic [1:0]  pack = PACK_OTHER;
	logic        inv = 1'b0;
	logic [7:0]  held = '0;
	bit          calm = 1'b0;
	bit          burst = 1'b0;
	int          hold_off_req = 0;

	dbb_poll_if   poll_ch ();
	dbb_result_if result_ch ();

	dash_button_buzzer_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (poll_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dbb_status_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.poll        (poll_ch),
		.result      (result_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic poll_t make_poll(input logic [1:0] action, input logic [31:0] now,
	                                    input logic [7:0] buttons, input logic [7:0] brake,
	                                    input logic inverter, input logic [1:0] cls,
	                                    input logic fault);
		poll_t p;
		p.action = action;
		p.now_ms = now;
		p.buttons = buttons;
		p.brake_pos = brake;
		p.inverter_on = inverter;
		p.pack_class = cls;
		p.pack_fault = fault;
		return p;
	endfunction

	function automatic poll_t next_poll();
		poll_t p;
		int    pick;
		int    b;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			p = make_poll(pick == 0 ? ACT_SPARE : (pick < 2 ? ACT_READY_OFF : ACT_READY_ON),
			              $urandom(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			              1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
			              1'($urandom_range(0, 1)));
			return p;
		end
		pick = $urandom_range(0, 99);
		if (pick < 2)
			tick = $urandom();
		else if (pick < 4)
			tick = '0;
		else
			tick = tick + $urandom_range(0, step_max);
		if ($urandom_range(0, 29) == 0) begin
			pack = PACK_UNUSED;
		end else if ($urandom_range(0, 5) == 0) begin
			case (pack)
				PACK_OTHER: pack = PACK_ENERGIZED;
				PACK_ENERGIZED: pack = ($urandom_range(0, 3) == 0) ? PACK_OTHER : PACK_DRIVE;
				PACK_DRIVE: pack = PACK_ENERGIZED;
				default: pack = PACK_OTHER;
			endcase
		end
		if ($urandom_range(0, pack == PACK_DRIVE ? 3 : 5) == 0)
			inv = !inv;
		if ($urandom_range(0, 7) == 0)
			held[BTN_READY] = !held[BTN_READY];
		if ($urandom_range(0, 7) == 0)
			held[BTN_AUTO] = !held[BTN_AUTO];
		if ($urandom_range(0, 2) == 0) begin
			b = $urandom_range(0, 255);
		end else begin
			b = int'(brake_floor) + int'($urandom_range(0, 6)) - 2;
			if (b < 0)
				b = 0;
			if (b > 255)
				b = 255;
		end
		p = make_poll(ACT_POLL, tick, (8'($urandom_range(0, 255)) & 8'hF9) | (held & 8'h06),
		              8'(b), inv, pack, 1'($urandom_range(0, 7) == 0));
		return p;
	endfunction

	task automatic send_poll(input poll_t p);
		if (!calm && !burst && $urandom_range(0, 5) == 0) begin
			poll_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.data <= p;
		do @(posedge clk); while (!poll_ch.ready);
	endtask

	task automatic run_polls(input int count);
		repeat (count) send_poll(next_poll());
	endtask

	task automatic wait_results_done();
		poll_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_regs(input logic [15:0] brake_word, input logic [15:0] hold,
	                        input logic [15:0] enter, input logic [15:0] leave);
		int unsigned longest;
		cfg_we <= 1'b1;
		cfg_index <= REG_BRAKE_MIN;
		cfg_data <= brake_word;
		@(posedge clk);
		cfg_index <= REG_HOLD_MS;
		cfg_data <= hold;
		@(posedge clk);
		cfg_index <= REG_ENTER_BUZZ_MS;
		cfg_data <= enter;
		@(posedge clk);
		cfg_index <= REG_EXIT_BUZZ_MS;
		cfg_data <= leave;
		@(posedge clk);
		cfg_we <= 1'b0;
		longest = hold;
		if (enter > longest)
			longest = enter;
		if (leave > longest)
			longest = leave;
		step_max = longest / 5 + 2;
		brake_floor = brake_word[7:0];
	endtask

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		int hold_off_seen;
		hold_off_seen = 0;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_req != hold_off_seen) begin
				hold_off_seen = hold_off_req;
				result_ch.ready <= 1'b0;
				repeat (150) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_BRAKE_MIN;
		cfg_data <= '0;
		poll_ch.valid <= 1'b0;
		poll_ch.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats under reset register values
		send_poll(make_poll(ACT_READY_ON, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, PACK_UNUSED, 1'b1));
		send_poll(make_poll(ACT_READY_OFF, 32'h0, 8'h00, 8'h00, 1'b0, PACK_OTHER, 1'b0));
		send_poll(make_poll(ACT_SPARE, 32'hA5A5_5A5A, 8'h5A, 8'hA5, 1'b1, PACK_DRIVE, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd0, 8'h00, 8'h00, 1'b0, PACK_ENERGIZED, 1'b0));
		// buzzer started at tick zero leaves its timer idle
		send_poll(make_poll(ACT_POLL, 32'd0, 8'h00, 8'h00, 1'b1, PACK_DRIVE, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd100, 8'h00, 8'h00, 1'b1, PACK_DRIVE, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd2100, 8'h00, 8'h00, 1'b1, PACK_DRIVE, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd2150, 8'h00, 8'h00, 1'b0, PACK_DRIVE, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd2200, 8'h00, 8'h00, 1'b0, PACK_ENERGIZED, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd2700, 8'hE0, 8'h00, 1'b0, PACK_ENERGIZED, 1'b1));
		send_poll(make_poll(ACT_POLL, 32'd2800, 8'h00, 8'h00, 1'b0, PACK_UNUSED, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd2900, 8'h02, 8'hFF, 1'b0, PACK_ENERGIZED, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd4800, 8'h02, 8'hFF, 1'b0, PACK_ENERGIZED, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd6800, 8'h02, 8'd20, 1'b1, PACK_DRIVE, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd8800, 8'h02, 8'd19, 1'b1, PACK_DRIVE, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd8900, 8'h04, 8'h00, 1'b0, PACK_OTHER, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd10800, 8'h04, 8'h00, 1'b0, PACK_OTHER, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'd10900, 8'h06, 8'hFF, 1'b0, PACK_OTHER, 1'b0));
		send_poll(make_poll(ACT_POLL, 32'hFFFF_FF00, 8'hFF, 8'hFF, 1'b1, PACK_ENERGIZED, 1'b1));
		send_poll(make_poll(ACT_POLL, 32'h0000_0700, 8'hFF, 8'hFF, 1'b1, PACK_DRIVE, 1'b1));
		send_poll(make_poll(ACT_READY_ON, 32'h0000_0800, 8'h00, 8'h00, 1'b0, PACK_OTHER, 1'b0));
		tick = 32'h0000_0800;
		run_polls(60);
		wait_results_done();

		set_regs(16'hFF00, 16'h0000, 16'h0000, 16'h0000);
		run_polls(90);
		wait_results_done();

		set_regs(16'h00FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		tick = 32'hFFF0_0000;
		run_polls(90);
		wait_results_done();

		// long result stall while polls keep coming, then a full pause
		set_regs({8'($urandom_range(0, 255)), 8'd40}, 16'd300, 16'd400, 16'd150);
		hold_off_req <= hold_off_req + 1;
		burst = 1'b1;
		run_polls(40);
		burst = 1'b0;
		run_polls(50);
		wait_results_done();
		run_polls(40);
		wait_results_done();

		set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 3000)),
		         16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)));
		run_polls(90);
		wait_results_done();

		calm = 1'b1;
		set_regs(16'd20, 16'd100, 16'd250, 16'd80);
		run_polls(90);
		wait_results_done();
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== dash_button_buzzer_controller_top.f =====
hdl/dbb_pkg.sv
hdl/dbb_if.sv
hdl/dbb_cfg_regs.sv
hdl/dbb_core.sv
hdl/dash_button_buzzer_controller_top.sv
hdl/dbb_checker.sv
sim/dbb_status_checker.sv
sim/dash_button_buzzer_controller_top_test.sv
